/* rtl/core/mfrp_pkg.sv */
// Package for the meter frame receive parser.
// Holds the parse phase and result kind types, the result record and the frame constants.
// No dependencies.
package mfrp_pkg;

    localparam logic [7:0] START_BYTE = 8'h68;
    localparam logic [7:0] DI_OFFSET = 8'h33;
    localparam logic [7:0] MIN_LENGTH = 8'd4;
    localparam logic [2:0] ADDR_BYTES = 3'd6;
    localparam logic [2:0] IDENT_BYTES = 3'd4;
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_ADDR    = 3'd1,
        PH_START2  = 3'd2,
        PH_CTRL    = 3'd3,
        PH_LEN     = 3'd4,
        PH_DI      = 3'd5,
        PH_PAYLOAD = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER     = 2'd0,
        KIND_PAYLOAD    = 2'd1,
        KIND_INCOMPLETE = 2'd2,
        KIND_BADLEN     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] data_identifier;
        logic [7:0]  payload_length;
        logic [7:0]  payload_byte;
        logic        frame_last;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

/* rtl/core/meter_frame_receive_parser_core.sv */
// Meter frame receive parser, top level: parser state machine feeding a result queue.
// Each accepted byte's results are written into the registered result queue, whose head drives the output.
// Throughput: one byte per cycle while the queue has room; a byte that yields two results leaves them one at a time.
// The input is ready while the four-entry result queue has room for two results.
// Reset: synchronous, active low; returns to hunting for the start byte with an empty queue.
module meter_frame_receive_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_end_of_buffer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [31:0] m_data_identifier,
    output logic [7:0]  m_payload_length,
    output logic [7:0]  m_payload_byte,
    output logic        m_frame_last
);

    logic              take;
    logic              room;
    mfrp_pkg::push_t   push;
    mfrp_pkg::result_t head;

    assign s_ready = room;
    assign take = s_valid && room;

    mfrp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (take),
        .rx_byte       (s_rx_byte),
        .end_of_buffer (s_end_of_buffer),
        .push          (push)
    );

    mfrp_result_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (m_valid && m_ready),
        .room       (room),
        .head_valid (m_valid),
        .head       (head)
    );

    assign m_result_kind = head.kind;
    assign m_data_identifier = head.data_identifier;
    assign m_payload_length = head.payload_length;
    assign m_payload_byte = head.payload_byte;
    assign m_frame_last = head.frame_last;

endmodule

/* rtl/core/mfrp_parser.sv */
// Byte-wise frame parser state machine for the meter frame receive parser.
// Produces up to two results per accepted byte. Depends on mfrp_pkg.
module mfrp_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             take,
    input  logic [7:0]       rx_byte,
    input  logic             end_of_buffer,
    output mfrp_pkg::push_t  push
);

    mfrp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [31:0]      acc_reg, acc_next;
    logic [7:0]       rem_reg, rem_next;

    logic [2:0]        cnt_inc;
    logic [7:0]        di_byte;
    logic [31:0]       acc_or;
    logic [7:0]        rem_dec;
    logic              main_valid;
    mfrp_pkg::result_t main_res;
    mfrp_pkg::result_t inc_res;
    logic              done;
    logic              incomplete;

    assign cnt_inc = cnt_reg + 3'd1;
    assign di_byte = rx_byte - mfrp_pkg::DI_OFFSET;
    assign acc_or  = acc_reg | (32'(di_byte) << {cnt_reg[1:0], 3'b000});
    assign rem_dec = rem_reg - 8'd1;

    // Result of the byte itself.
    always_comb begin
        main_valid = 1'b0;
        main_res = '0;
        case (phase_reg)
            mfrp_pkg::PH_LEN: begin
                if (rx_byte < mfrp_pkg::MIN_LENGTH) begin
                    main_valid = 1'b1;
                    main_res.kind = mfrp_pkg::KIND_BADLEN;
                    main_res.frame_last = 1'b1;
                end
            end
            mfrp_pkg::PH_DI: begin
                if (cnt_inc >= mfrp_pkg::IDENT_BYTES) begin
                    main_valid = 1'b1;
                    main_res.kind = mfrp_pkg::KIND_HEADER;
                    main_res.data_identifier = acc_or;
                    main_res.payload_length = rem_reg;
                    main_res.frame_last = (rem_reg == 8'd0);
                end
            end
            mfrp_pkg::PH_PAYLOAD: begin
                main_valid = 1'b1;
                main_res.kind = mfrp_pkg::KIND_PAYLOAD;
                main_res.payload_byte = rx_byte;
                main_res.frame_last = (rem_dec == 8'd0);
            end
            default: begin
                main_valid = 1'b0;
            end
        endcase
    end

    assign done = main_valid && main_res.frame_last;
    assign incomplete = end_of_buffer && !done;

    always_comb begin
        inc_res = '0;
        inc_res.kind = mfrp_pkg::KIND_INCOMPLETE;
        inc_res.frame_last = 1'b1;
        push.num = take ? (2'(main_valid) + 2'(incomplete)) : 2'd0;
        push.first = main_valid ? main_res : inc_res;
        push.second = inc_res;
    end

    // Next state.
    always_comb begin
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        case (phase_reg)
            mfrp_pkg::PH_HUNT: begin
                if (rx_byte == mfrp_pkg::START_BYTE) begin
                    phase_next = mfrp_pkg::PH_ADDR;
                    cnt_next = 3'd0;
                end
            end
            mfrp_pkg::PH_ADDR: begin
                if (cnt_inc >= mfrp_pkg::ADDR_BYTES) begin
                    phase_next = mfrp_pkg::PH_START2;
                    cnt_next = 3'd0;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            mfrp_pkg::PH_START2: begin
                phase_next = mfrp_pkg::PH_CTRL;
            end
            mfrp_pkg::PH_CTRL: begin
                phase_next = mfrp_pkg::PH_LEN;
            end
            mfrp_pkg::PH_LEN: begin
                if (rx_byte < mfrp_pkg::MIN_LENGTH) begin
                    phase_next = mfrp_pkg::PH_HUNT;
                end else begin
                    rem_next = rx_byte - mfrp_pkg::MIN_LENGTH;
                    acc_next = 32'd0;
                    cnt_next = 3'd0;
                    phase_next = mfrp_pkg::PH_DI;
                end
            end
            mfrp_pkg::PH_DI: begin
                acc_next = acc_or;
                if (cnt_inc >= mfrp_pkg::IDENT_BYTES) begin
                    cnt_next = 3'd0;
                    phase_next = (rem_reg == 8'd0) ? mfrp_pkg::PH_HUNT : mfrp_pkg::PH_PAYLOAD;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            mfrp_pkg::PH_PAYLOAD: begin
                rem_next = rem_dec;
                if (rem_dec == 8'd0) begin
                    phase_next = mfrp_pkg::PH_HUNT;
                end
            end
            default: begin
                phase_next = mfrp_pkg::PH_HUNT;
            end
        endcase
        if (incomplete) begin
            phase_next = mfrp_pkg::PH_HUNT;
            cnt_next = 3'd0;
            rem_next = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mfrp_pkg::PH_HUNT;
            cnt_reg <= 3'd0;
            acc_reg <= 32'd0;
            rem_reg <= 8'd0;
        end else if (take) begin
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

endmodule

/* rtl/core/mfrp_result_fifo.sv */
// Result queue for the meter frame receive parser: takes up to two results a cycle
// and presents one at a time. Depends on mfrp_pkg.
module mfrp_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  mfrp_pkg::push_t   push,
    input  logic              pop,
    output logic              room,
    output logic              head_valid,
    output mfrp_pkg::result_t head
);

    localparam int PtrW = $clog2(mfrp_pkg::FIFO_DEPTH);
    localparam int CntW = PtrW + 1;

    mfrp_pkg::result_t entries_reg [mfrp_pkg::FIFO_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic [PtrW-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PtrW'(1);
    assign room = (count_reg <= CntW'(mfrp_pkg::FIFO_DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push.num);
        rd_ptr_next = rd_ptr_reg + PtrW'(pop);
        count_next = count_reg + CntW'(push.num) - CntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            entries_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

/* rtl/core/mfrp_checker.sv */
// Port-level checks for the meter frame receive parser.
// Depends on mfrp_pkg; bound to meter_frame_receive_parser_core.
module mfrp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_result_kind,
    input logic [31:0] m_data_identifier,
    input logic [7:0]  m_payload_length,
    input logic [7:0]  m_payload_byte,
    input logic        m_frame_last
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) && $stable(m_frame_last)
            && $stable(m_data_identifier) && $stable(m_payload_byte))
        else $error("stalled result changed");

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == 2'(mfrp_pkg::KIND_INCOMPLETE)
            || m_result_kind == 2'(mfrp_pkg::KIND_BADLEN))
        |-> m_frame_last && m_data_identifier == 32'd0 && m_payload_length == 8'd0
            && m_payload_byte == 8'd0)
        else $error("error result has bad fields");

    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == 2'(mfrp_pkg::KIND_PAYLOAD)
        |-> m_data_identifier == 32'd0 && m_payload_length == 8'd0)
        else $error("payload result carries header fields");

    a_empty_header_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == 2'(mfrp_pkg::KIND_HEADER) && m_payload_length == 8'd0
        |-> m_frame_last)
        else $error("header with empty payload not marked last");

endmodule

bind meter_frame_receive_parser_core mfrp_checker u_mfrp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_result_kind     (m_result_kind),
    .m_data_identifier (m_data_identifier),
    .m_payload_length  (m_payload_length),
    .m_payload_byte    (m_payload_byte),
    .m_frame_last      (m_frame_last)
);

/* bench/meter_frame_receive_parser_core_tb.sv */
// Self-checking testbench for meter_frame_receive_parser_core: directed start, random frames.
// A scoreboard class predicts every result from the accepted bytes and checks them in order.
// Depends on mfrp_pkg and the meter_frame_receive_parser_core RTL.
import mfrp_pkg::*;

class frame_result_scoreboard;
    phase_t      phase_now;
    logic [2:0]  addr_di_count;
    logic [31:0] ident_acc;
    logic [7:0]  bytes_left;
    result_t     expected_results[$];
    int          errors;

    function new();
        phase_now = PH_HUNT;
        addr_di_count = 3'd0;
        ident_acc = 32'd0;
        bytes_left = 8'd0;
        errors = 0;
    endfunction

    function void push(kind_t k, logic [31:0] di, logic [7:0] plen, logic [7:0] pbyte,
                       logic last);
        result_t r;
        r.kind = k;
        r.data_identifier = di;
        r.payload_length = plen;
        r.payload_byte = pbyte;
        r.frame_last = last;
        expected_results.push_back(r);
    endfunction

    function void note_request(logic [7:0] b, logic eob);
        logic       done;
        logic [7:0] di_byte;
        done = 1'b0;
        case (phase_now)
            PH_HUNT: begin
                if (b == START_BYTE) begin
                    phase_now = PH_ADDR;
                    addr_di_count = 3'd0;
                end
            end
            PH_ADDR: begin
                addr_di_count = addr_di_count + 3'd1;
                if (addr_di_count >= ADDR_BYTES) begin
                    phase_now = PH_START2;
                    addr_di_count = 3'd0;
                end
            end
            PH_START2: phase_now = PH_CTRL;
            PH_CTRL: phase_now = PH_LEN;
            PH_LEN: begin
                if (b < MIN_LENGTH) begin
                    push(KIND_BADLEN, 32'd0, 8'd0, 8'd0, 1'b1);
                    phase_now = PH_HUNT;
                    done = 1'b1;
                end else begin
                    bytes_left = b - MIN_LENGTH;
                    ident_acc = 32'd0;
                    addr_di_count = 3'd0;
                    phase_now = PH_DI;
                end
            end
            PH_DI: begin
                di_byte = b - DI_OFFSET;
                ident_acc = ident_acc | ({24'd0, di_byte} << {addr_di_count[1:0], 3'b000});
                addr_di_count = addr_di_count + 3'd1;
                if (addr_di_count >= IDENT_BYTES) begin
                    addr_di_count = 3'd0;
                    if (bytes_left == 8'd0) begin
                        push(KIND_HEADER, ident_acc, 8'd0, 8'd0, 1'b1);
                        phase_now = PH_HUNT;
                        done = 1'b1;
                    end else begin
                        push(KIND_HEADER, ident_acc, bytes_left, 8'd0, 1'b0);
                        phase_now = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) begin
                    push(KIND_PAYLOAD, 32'd0, 8'd0, b, 1'b1);
                    phase_now = PH_HUNT;
                    done = 1'b1;
                end else begin
                    push(KIND_PAYLOAD, 32'd0, 8'd0, b, 1'b0);
                end
            end
            default: phase_now = PH_HUNT;
        endcase
        if (eob && !done) begin
            push(KIND_INCOMPLETE, 32'd0, 8'd0, 8'd0, 1'b1);
            phase_now = PH_HUNT;
            addr_di_count = 3'd0;
            bytes_left = 8'd0;
        end
    endfunction

    task report(string what);
        $display("MISMATCH: %s", what);
        errors++;
    endtask

    task check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0) begin
            report($sformatf("unexpected result of kind %0d", got.kind));
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind)
            report($sformatf("result_kind expected %0d got %0d", want.kind, got.kind));
        if (got.data_identifier !== want.data_identifier)
            report($sformatf("data_identifier expected %h got %h",
                             want.data_identifier, got.data_identifier));
        if (got.payload_length !== want.payload_length)
            report($sformatf("payload_length expected %0d got %0d",
                             want.payload_length, got.payload_length));
        if (got.payload_byte !== want.payload_byte)
            report($sformatf("payload_byte expected %h got %h",
                             want.payload_byte, got.payload_byte));
        if (got.frame_last !== want.frame_last)
            report($sformatf("frame_last expected %0d got %0d", want.frame_last, got.frame_last));
    endtask
endclass

module meter_frame_receive_parser_core_tb;
    localparam logic [7:0] END_BYTE = 8'h16;
    localparam int REQUEST_TARGET = 1450;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'd0;
    logic        s_end_of_buffer = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [1:0]  m_result_kind;
    logic [31:0] m_data_identifier;
    logic [7:0]  m_payload_length;
    logic [7:0]  m_payload_byte;
    logic        m_frame_last;

    frame_result_scoreboard bench = new();
    logic quiet_mode = 1'b0;
    int   requests_sent = 0;
    int   out_hold = 0;

    meter_frame_receive_parser_core DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .s_end_of_buffer   (s_end_of_buffer),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_data_identifier (m_data_identifier),
        .m_payload_length  (m_payload_length),
        .m_payload_byte    (m_payload_byte),
        .m_frame_last      (m_frame_last)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind = kind_t'(m_result_kind);
            got.data_identifier = m_data_identifier;
            got.payload_length = m_payload_length;
            got.payload_byte = m_payload_byte;
            got.frame_last = m_frame_last;
            bench.check_result(got);
            out_hold = quiet_mode ? 0 : $urandom_range(0, 3);
            if (out_hold > 0)
                m_ready <= 1'b0;
        end else if (out_hold > 0) begin
            out_hold = out_hold - 1;
            if (out_hold == 0)
                m_ready <= 1'b1;
        end
    end

    task automatic send_request(input logic [7:0] b, input logic eob);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        s_end_of_buffer <= eob;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bench.note_request(b, eob);
        requests_sent++;
    endtask

    task automatic send_bytes(input logic [7:0] bytes_q[$], input int cut);
        for (int i = 0; i < bytes_q.size(); i++) begin
            send_request(bytes_q[i], i == cut);
            if (i == cut)
                break;
        end
    endtask

    initial begin
        logic [7:0] frame[$];
        logic [7:0] len;
        int         cut;
        int         frame_no;
        frame_no = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Buffer end while hunting, an empty-payload frame, then a short length
        // that arrives together with the buffer end.
        send_request(8'hFF, 1'b1);
        frame = '{8'h68, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h04,
                  8'h00, 8'hFF, 8'h33, 8'h32};
        send_bytes(frame, -1);
        frame = '{8'h68, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h68, 8'h11, 8'h03};
        send_bytes(frame, 9);

        while (requests_sent < REQUEST_TARGET) begin
            quiet_mode = ($urandom_range(0, 7) == 0);
            frame.delete();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(0, 255)));
                send_bytes(frame, $urandom_range(0, 1) ? frame.size() - 1 : -1);
            end else begin
                repeat ($urandom_range(0, 2)) frame.push_back(8'($urandom_range(0, 255)));
                frame.push_back(START_BYTE);
                repeat (ADDR_BYTES) frame.push_back(8'($urandom_range(0, 255)));
                frame.push_back($urandom_range(0, 1) ? START_BYTE : 8'($urandom_range(0, 255)));
                frame.push_back(8'($urandom_range(0, 255)));
                case ($urandom_range(0, 9))
                    0: len = 8'($urandom_range(0, 3));
                    1: len = MIN_LENGTH;
                    default: len = 8'($urandom_range(5, 20));
                endcase
                if (frame_no == 7)
                    len = 8'hFF;
                frame.push_back(len);
                if (len >= MIN_LENGTH)
                    repeat (len) frame.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) != 0) begin
                    frame.push_back(8'($urandom_range(0, 255)));
                    frame.push_back(END_BYTE);
                end
                cut = -1;
                if ($urandom_range(0, 5) == 0)
                    cut = $urandom_range(0, frame.size() - 1);
                else if ($urandom_range(0, 3) == 0)
                    cut = frame.size() - 1;
                send_bytes(frame, cut);
                frame_no++;
            end
        end
        s_valid <= 1'b0;
        quiet_mode = 1'b0;

        while (bench.expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (bench.errors == 0 && bench.expected_results.size() == 0)
            $display("meter_frame_receive_parser_core verification clean");
        else
            $display("meter_frame_receive_parser_core verification failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("meter_frame_receive_parser_core verification failed");
        $finish;
    end
endmodule
